// File: sv/pdsf_pkg.sv
// Shared types, codes and decode functions for the Y86-64 decode stage.
package pdsf_pkg;

  localparam logic [3:0] RNONE = 4'hF;
  localparam logic [3:0] RSP   = 4'h4;

  localparam logic [3:0] I_NOP    = 4'h1;
  localparam logic [3:0] I_RRMOVQ = 4'h2;
  localparam logic [3:0] I_IRMOVQ = 4'h3;
  localparam logic [3:0] I_RMMOVQ = 4'h4;
  localparam logic [3:0] I_MRMOVQ = 4'h5;
  localparam logic [3:0] I_OPQ    = 4'h6;
  localparam logic [3:0] I_JXX    = 4'h7;
  localparam logic [3:0] I_CALL   = 4'h8;
  localparam logic [3:0] I_RET    = 4'h9;
  localparam logic [3:0] I_PUSHQ  = 4'hA;
  localparam logic [3:0] I_POPQ   = 4'hB;

  localparam logic [2:0] STAT_BUBBLE = 3'd0;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STALL  = 2'd1,
    OP_BUBBLE = 2'd2
  } op_t;

  // Writeback port into the register file
  typedef struct packed {
    logic [3:0]  dste;
    logic [3:0]  dstm;
    logic [63:0] vale;
    logic [63:0] valm;
  } wb_t;

  function automatic logic [3:0] src_a(input logic [3:0] ic, input logic [3:0] ra);
    logic [3:0] r;
    case (ic)
      I_RRMOVQ, I_RMMOVQ, I_OPQ, I_PUSHQ: r = ra;
      I_POPQ, I_RET:                      r = RSP;
      default:                            r = RNONE;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] src_b(input logic [3:0] ic, input logic [3:0] rb);
    logic [3:0] r;
    case (ic)
      I_RMMOVQ, I_MRMOVQ, I_OPQ:        r = rb;
      I_PUSHQ, I_POPQ, I_CALL, I_RET:   r = RSP;
      default:                          r = RNONE;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] dst_e(input logic [3:0] ic, input logic [3:0] rb);
    logic [3:0] r;
    case (ic)
      I_RRMOVQ, I_IRMOVQ, I_OPQ:        r = rb;
      I_PUSHQ, I_POPQ, I_CALL, I_RET:   r = RSP;
      default:                          r = RNONE;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] dst_m(input logic [3:0] ic, input logic [3:0] ra);
    logic [3:0] r;
    case (ic)
      I_MRMOVQ, I_POPQ: r = ra;
      default:          r = RNONE;
    endcase
    return r;
  endfunction

endpackage

// File: sv/pdsf_regfile.sv
// Register file: two write banks with a last-writer table, registered reads.
module pdsf_regfile import pdsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        acc,
  input  wb_t         wb,
  input  logic [3:0]  rd_addr_a,
  input  logic [3:0]  rd_addr_b,
  output logic [63:0] rd_a,
  output logic [63:0] rd_b
);

  localparam int Depth = 15;

  logic [63:0] bank_e [0:Depth-1];
  logic [63:0] bank_m [0:Depth-1];
  logic [Depth-1:0] valid;
  logic [Depth-1:0] pick_m;

  logic [63:0] qe_a, qm_a, qe_b, qm_b;
  logic        ok_a, ok_b, sm_a, sm_b;

  // Write and read on the same beat; reads see the contents before the write
  always_ff @(posedge clk) begin
    if (acc) begin
      if (wb.dste != RNONE) bank_e[wb.dste] <= wb.vale;
      if (wb.dstm != RNONE) bank_m[wb.dstm] <= wb.valm;
      qe_a <= bank_e[rd_addr_a];
      qm_a <= bank_m[rd_addr_a];
      qe_b <= bank_e[rd_addr_b];
      qm_b <= bank_m[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (acc) begin
      ok_a <= (rd_addr_a != RNONE) && valid[rd_addr_a];
      ok_b <= (rd_addr_b != RNONE) && valid[rd_addr_b];
      sm_a <= pick_m[rd_addr_a];
      sm_b <= pick_m[rd_addr_b];
      // memory port wins when both name the same register
      if (wb.dste != RNONE && wb.dste != wb.dstm) begin
        valid[wb.dste]  <= 1'b1;
        pick_m[wb.dste] <= 1'b0;
      end
      if (wb.dstm != RNONE) begin
        valid[wb.dstm]  <= 1'b1;
        pick_m[wb.dstm] <= 1'b1;
      end
    end
  end

  assign rd_a = ok_a ? (sm_a ? qm_a : qe_a) : 64'd0;
  assign rd_b = ok_b ? (sm_b ? qm_b : qe_b) : 64'd0;

endmodule

// File: sv/pdsf_fwd.sv
// Forwarding select for one operand: priority over five bypass paths.
module pdsf_fwd import pdsf_pkg::*; (
  input  logic [3:0]  src,
  input  logic [19:0] dsts,
  input  logic [63:0] val_ee,
  input  logic [63:0] val_mm,
  input  logic [63:0] val_me,
  input  logic [63:0] val_wm,
  input  logic [63:0] val_we,
  input  logic [63:0] rf_val,
  output logic [63:0] val
);

  // The none code takes part in the compares as well
  always_comb begin
    if (src == dsts[3:0])        val = val_ee;
    else if (src == dsts[7:4])   val = val_mm;
    else if (src == dsts[11:8])  val = val_me;
    else if (src == dsts[15:12]) val = val_wm;
    else if (src == dsts[19:16]) val = val_we;
    else                         val = rf_val;
  end

endmodule

// File: sv/pipelined_decode_stage_forwarding.sv
// Decode stage top level: pipeline register, register file read, forwarding, output register.
//
//   channel  handshake             payload
//   input    in_valid / in_stall   op f_stat f_code f_regs f_valc f_valp fwd_dsts, five values
//   output   out_valid / out_stall d_stat d_icode d_ifun d_valc d_vala d_valb d_dste d_dstm
//                                  d_srca d_srcb
//
// One beat in and one beat out per cycle while no stall holds the flow.
// A beat passes the decode register and the registered register-file read, then the output register.
// Reset clears the decode register to a bubble and the register file to zero.
// A stall on the output holds the output register; the input stalls only when both stages are
// full and the output cannot move.
module pipelined_decode_stage_forwarding import pdsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [2:0]  f_stat,
  input  logic [7:0]  f_code,
  input  logic [7:0]  f_regs,
  input  logic [63:0] f_valc,
  input  logic [63:0] f_valp,
  input  logic [19:0] fwd_dsts,
  input  logic [63:0] exe_val_e,
  input  logic [63:0] mem_val_m,
  input  logic [63:0] mem_val_e,
  input  logic [63:0] wb_val_m,
  input  logic [63:0] wb_val_e,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  d_stat,
  output logic [3:0]  d_icode,
  output logic [3:0]  d_ifun,
  output logic [63:0] d_valc,
  output logic [63:0] d_vala,
  output logic [63:0] d_valb,
  output logic [3:0]  d_dste,
  output logic [3:0]  d_dstm,
  output logic [3:0]  d_srca,
  output logic [3:0]  d_srcb
);

  logic acc, s1_valid, s1_move;

  logic [2:0]  held_stat,  held_stat_next;
  logic [3:0]  held_icode, held_icode_next;
  logic [3:0]  held_ifun,  held_ifun_next;
  logic [3:0]  held_ra,    held_ra_next;
  logic [3:0]  held_rb,    held_rb_next;
  logic [63:0] held_valc,  held_valc_next;
  logic [63:0] held_valp,  held_valp_next;

  logic [19:0] s1_dsts;
  logic [63:0] s1_ee, s1_mm, s1_me, s1_wm, s1_we;

  wb_t         wb;
  logic [63:0] rf_a, rf_b, fwd_a, fwd_b, vala;
  logic [3:0]  srca, srcb;

  assign acc      = in_valid && !in_stall;
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;

  always_comb begin
    held_stat_next  = held_stat;
    held_icode_next = held_icode;
    held_ifun_next  = held_ifun;
    held_ra_next    = held_ra;
    held_rb_next    = held_rb;
    held_valc_next  = held_valc;
    held_valp_next  = held_valp;
    case (op)
      OP_LOAD: begin
        held_stat_next  = f_stat;
        held_icode_next = f_code[7:4];
        held_ifun_next  = f_code[3:0];
        held_ra_next    = f_regs[7:4];
        held_rb_next    = f_regs[3:0];
        held_valc_next  = f_valc;
        held_valp_next  = f_valp;
      end
      OP_BUBBLE: begin
        held_stat_next  = STAT_BUBBLE;
        held_icode_next = I_NOP;
        held_ifun_next  = 4'd0;
        held_ra_next    = RNONE;
        held_rb_next    = RNONE;
        held_valc_next  = 64'd0;
        held_valp_next  = 64'd0;
      end
      default: begin
        // hold on stall and on the unused code
        held_stat_next = held_stat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_stat  <= STAT_BUBBLE;
      held_icode <= I_NOP;
      held_ifun  <= 4'd0;
      held_ra    <= RNONE;
      held_rb    <= RNONE;
      held_valc  <= 64'd0;
      held_valp  <= 64'd0;
    end else if (acc) begin
      held_stat  <= held_stat_next;
      held_icode <= held_icode_next;
      held_ifun  <= held_ifun_next;
      held_ra    <= held_ra_next;
      held_rb    <= held_rb_next;
      held_valc  <= held_valc_next;
      held_valp  <= held_valp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_dsts <= fwd_dsts;
      s1_ee   <= exe_val_e;
      s1_mm   <= mem_val_m;
      s1_me   <= mem_val_e;
      s1_wm   <= wb_val_m;
      s1_we   <= wb_val_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  assign wb.dste = fwd_dsts[19:16];
  assign wb.dstm = fwd_dsts[15:12];
  assign wb.vale = wb_val_e;
  assign wb.valm = wb_val_m;

  pdsf_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .wb        (wb),
    .rd_addr_a (src_a(held_icode_next, held_ra_next)),
    .rd_addr_b (src_b(held_icode_next, held_rb_next)),
    .rd_a      (rf_a),
    .rd_b      (rf_b)
  );

  assign srca = src_a(held_icode, held_ra);
  assign srcb = src_b(held_icode, held_rb);

  pdsf_fwd u_fwd_a (
    .src    (srca),
    .dsts   (s1_dsts),
    .val_ee (s1_ee),
    .val_mm (s1_mm),
    .val_me (s1_me),
    .val_wm (s1_wm),
    .val_we (s1_we),
    .rf_val (rf_a),
    .val    (fwd_a)
  );

  pdsf_fwd u_fwd_b (
    .src    (srcb),
    .dsts   (s1_dsts),
    .val_ee (s1_ee),
    .val_mm (s1_mm),
    .val_me (s1_me),
    .val_wm (s1_wm),
    .val_we (s1_we),
    .rf_val (rf_b),
    .val    (fwd_b)
  );

  // jump and call carry the next PC in valA
  assign vala = (held_icode == I_JXX || held_icode == I_CALL) ? held_valp : fwd_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      d_stat  <= held_stat;
      d_icode <= held_icode;
      d_ifun  <= held_ifun;
      d_valc  <= held_valc;
      d_vala  <= vala;
      d_valb  <= fwd_b;
      d_dste  <= dst_e(held_icode, held_rb);
      d_dstm  <= dst_m(held_icode, held_ra);
      d_srca  <= srca;
      d_srcb  <= srcb;
    end
  end

endmodule

// File: tb/sv/decode_stage_checker.sv
// Checker for the decode stage: predicts each decoded beat and compares the result channel.
module decode_stage_checker import pdsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic [2:0]  f_stat,
  input  logic [7:0]  f_code,
  input  logic [7:0]  f_regs,
  input  logic [63:0] f_valc,
  input  logic [63:0] f_valp,
  input  logic [19:0] fwd_dsts,
  input  logic [63:0] exe_val_e,
  input  logic [63:0] mem_val_m,
  input  logic [63:0] mem_val_e,
  input  logic [63:0] wb_val_m,
  input  logic [63:0] wb_val_e,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  d_stat,
  input  logic [3:0]  d_icode,
  input  logic [3:0]  d_ifun,
  input  logic [63:0] d_valc,
  input  logic [63:0] d_vala,
  input  logic [63:0] d_valb,
  input  logic [3:0]  d_dste,
  input  logic [3:0]  d_dstm,
  input  logic [3:0]  d_srca,
  input  logic [3:0]  d_srcb,
  output int          errors,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [2:0]  stat;
    logic [3:0]  icode;
    logic [3:0]  ifun;
    logic [63:0] valc;
    logic [63:0] vala;
    logic [63:0] valb;
    logic [3:0]  dste;
    logic [3:0]  dstm;
    logic [3:0]  srca;
    logic [3:0]  srcb;
  } decoded_t;

  // Decode pipeline register and register file as the stage sees them
  logic [2:0]  dec_stat;
  logic [3:0]  dec_icode;
  logic [3:0]  dec_ifun;
  logic [3:0]  dec_ra;
  logic [3:0]  dec_rb;
  logic [63:0] dec_valc;
  logic [63:0] dec_valp;
  logic [63:0] gpr [0:14];

  decoded_t decoded_q[$];

  // Priority: e_dstE, M_dstM, M_dstE, W_dstM, W_dstE, then the register file
  function automatic logic [63:0] operand(input logic [3:0] src, input logic [19:0] dsts,
                                          input logic [4:0][63:0] vals);
    for (int k = 0; k < 5; k++)
      if (src == dsts[4*k +: 4]) return vals[k];
    return (src == RNONE) ? 64'd0 : gpr[src];
  endfunction

  function automatic int field_diff(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic decode_beat();
    decoded_t d;
    logic [4:0][63:0] vals;
    case (op)
      OP_LOAD: begin
        dec_stat  = f_stat;
        dec_icode = f_code[7:4];
        dec_ifun  = f_code[3:0];
        dec_ra    = f_regs[7:4];
        dec_rb    = f_regs[3:0];
        dec_valc  = f_valc;
        dec_valp  = f_valp;
      end
      OP_BUBBLE: begin
        dec_stat  = STAT_BUBBLE;
        dec_icode = I_NOP;
        dec_ifun  = '0;
        dec_ra    = RNONE;
        dec_rb    = RNONE;
        dec_valc  = '0;
        dec_valp  = '0;
      end
      default: ;  // hold, including the unnamed op code
    endcase

    vals = {wb_val_e, wb_val_m, mem_val_e, mem_val_m, exe_val_e};
    d.stat  = dec_stat;
    d.icode = dec_icode;
    d.ifun  = dec_ifun;
    d.valc  = dec_valc;

    case (dec_icode)
      I_RRMOVQ, I_RMMOVQ, I_OPQ, I_PUSHQ: d.srca = dec_ra;
      I_POPQ, I_RET:                      d.srca = RSP;
      default:                            d.srca = RNONE;
    endcase
    case (dec_icode)
      I_RMMOVQ, I_MRMOVQ, I_OPQ:      d.srcb = dec_rb;
      I_PUSHQ, I_POPQ, I_CALL, I_RET: d.srcb = RSP;
      default:                        d.srcb = RNONE;
    endcase
    case (dec_icode)
      I_RRMOVQ, I_IRMOVQ, I_OPQ:      d.dste = dec_rb;
      I_PUSHQ, I_POPQ, I_CALL, I_RET: d.dste = RSP;
      default:                        d.dste = RNONE;
    endcase
    d.dstm = (dec_icode == I_MRMOVQ || dec_icode == I_POPQ) ? dec_ra : RNONE;

    // jump and call carry valP in valA and skip forwarding
    d.vala = (dec_icode == I_JXX || dec_icode == I_CALL) ? dec_valp
                                                          : operand(d.srca, fwd_dsts, vals);
    d.valb = operand(d.srcb, fwd_dsts, vals);
    decoded_q.push_back(d);

    // writeback after the read; the M port wins a shared destination
    if (fwd_dsts[19:16] != RNONE) gpr[fwd_dsts[19:16]] = wb_val_e;
    if (fwd_dsts[15:12] != RNONE) gpr[fwd_dsts[15:12]] = wb_val_m;
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      dec_stat  = STAT_BUBBLE;
      dec_icode = I_NOP;
      dec_ifun  = '0;
      dec_ra    = RNONE;
      dec_rb    = RNONE;
      dec_valc  = '0;
      dec_valp  = '0;
      for (int i = 0; i < 15; i++) gpr[i] = '0;
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result beat with no decoded beat waiting");
          errors++;
        end else begin
          want = decoded_q.pop_front();
          errors += field_diff("d_stat", want.stat, d_stat)
                  + field_diff("d_icode", want.icode, d_icode)
                  + field_diff("d_ifun", want.ifun, d_ifun)
                  + field_diff("d_valc", want.valc, d_valc)
                  + field_diff("d_vala", want.vala, d_vala)
                  + field_diff("d_valb", want.valb, d_valb)
                  + field_diff("d_dste", want.dste, d_dste)
                  + field_diff("d_dstm", want.dstm, d_dstm)
                  + field_diff("d_srca", want.srca, d_srca)
                  + field_diff("d_srcb", want.srcb, d_srcb);
          checked++;
        end
      end
      if (in_valid && !in_stall) decode_beat();
    end
    pending = decoded_q.size();
  end

endmodule

// File: tb/sv/pipelined_decode_stage_forwarding_tb.sv
// Testbench top for the decode stage: clock, reset, stimulus, output back-pressure and verdict.
module pipelined_decode_stage_forwarding_tb;
  import pdsf_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;  // unnamed op code, behaves as a hold
  localparam int RANDOM_BEATS = 700;
  localparam int CALM_TAIL    = 120;

  typedef struct packed {
    logic [1:0]       op;
    logic [2:0]       stat;
    logic [7:0]       code;
    logic [7:0]       regs;
    logic [63:0]      valc;
    logic [63:0]      valp;
    logic [19:0]      dsts;
    logic [4:0][63:0] fwd;  // exe_val_e, mem_val_m, mem_val_e, wb_val_m, wb_val_e
  } beat_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  out_stall = 1'b0;
  beat_t cur = '0;
  logic  in_stall, out_valid;
  logic [2:0]  d_stat;
  logic [3:0]  d_icode, d_ifun, d_dste, d_dstm, d_srca, d_srcb;
  logic [63:0] d_valc, d_vala, d_valb;
  int errors, pending, checked;
  int sent = 0;
  int n_directed = 0;
  bit calm = 1'b0;

  pipelined_decode_stage_forwarding dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(cur.op), .f_stat(cur.stat), .f_code(cur.code), .f_regs(cur.regs),
    .f_valc(cur.valc), .f_valp(cur.valp), .fwd_dsts(cur.dsts),
    .exe_val_e(cur.fwd[0]), .mem_val_m(cur.fwd[1]), .mem_val_e(cur.fwd[2]),
    .wb_val_m(cur.fwd[3]), .wb_val_e(cur.fwd[4]),
    .out_valid(out_valid), .out_stall(out_stall),
    .d_stat(d_stat), .d_icode(d_icode), .d_ifun(d_ifun), .d_valc(d_valc),
    .d_vala(d_vala), .d_valb(d_valb), .d_dste(d_dste), .d_dstm(d_dstm),
    .d_srca(d_srca), .d_srcb(d_srcb)
  );

  decode_stage_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(cur.op), .f_stat(cur.stat), .f_code(cur.code), .f_regs(cur.regs),
    .f_valc(cur.valc), .f_valp(cur.valp), .fwd_dsts(cur.dsts),
    .exe_val_e(cur.fwd[0]), .mem_val_m(cur.fwd[1]), .mem_val_e(cur.fwd[2]),
    .wb_val_m(cur.fwd[3]), .wb_val_e(cur.fwd[4]),
    .out_valid(out_valid), .out_stall(out_stall),
    .d_stat(d_stat), .d_icode(d_icode), .d_ifun(d_ifun), .d_valc(d_valc),
    .d_vala(d_vala), .d_valb(d_valb), .d_dste(d_dste), .d_dstm(d_dstm),
    .d_srca(d_srca), .d_srcb(d_srcb),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 300000);
    $display("pipelined_decode_stage_forwarding: mismatch");
    $finish;
  end

  function automatic logic [63:0] wide_rand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic beat_t directed_beat(input logic [1:0] op, input logic [7:0] code,
                                          input logic [7:0] regs, input logic [19:0] dsts);
    beat_t b;
    b.op   = op;
    b.stat = 3'($urandom_range(0, 7));
    b.code = code;
    b.regs = regs;
    b.valc = wide_rand();
    b.valp = wide_rand();
    b.dsts = dsts;
    for (int k = 0; k < 5; k++) b.fwd[k] = wide_rand();
    return b;
  endfunction

  // Drop valid for the gap, then offer the beat and hold it until it is taken
  task automatic send_beat(input beat_t b, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cur      <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Result side: random hold-offs plus one long stretch to back the stage up
  initial begin
    int  n;
    bit  pressed;
    pressed = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && sent >= 250) begin
        pressed = 1'b1;
        out_stall <= 1'b1;
        repeat (80) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && (sent / 48) % 3 != 1 && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    beat_t      b;
    logic [3:0] ic, ra, rb;
    int         gap;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // hold right after reset shows the reset bubble
    send_beat(directed_beat(OP_STALL, 8'h00, 8'h00, 20'hFFFFF), 0);
    b = directed_beat(OP_LOAD, 8'h00, 8'h00, 20'h00000);
    b.stat = '0; b.valc = '0; b.valp = '0; b.fwd = '0;
    send_beat(b, 0);
    // none sources match none destinations and pick up exe_val_e
    b = directed_beat(OP_LOAD, 8'hFF, 8'hFF, 20'hFFFFF);
    b.stat = '1; b.valc = '1; b.valp = '1; b.fwd = '1;
    send_beat(b, 0);
    for (int i = I_NOP; i <= I_POPQ; i++) begin
      ic = 4'(i);
      ra = ic - 4'd1;
      rb = (ic + 4'd3) % 4'd15;
      send_beat(directed_beat(OP_LOAD, {ic, ic}, {ra, rb},
                              {ra, ra, (ic[0] ? RSP : rb), rb, (ic[1] ? ra : RNONE)}), 0);
    end
    for (int i = 12; i <= 14; i++) begin
      ic = 4'(i);
      send_beat(directed_beat(OP_LOAD, {ic, 4'($urandom)}, 8'($urandom), 20'($urandom)), 0);
    end
    send_beat(directed_beat(OP_RESERVED, 8'($urandom), 8'($urandom), 20'($urandom)), 0);
    send_beat(directed_beat(OP_BUBBLE, 8'($urandom), 8'($urandom), 20'($urandom)), 0);
    // write r5 through W_dstE, then read it back with no forwarding path
    send_beat(directed_beat(OP_LOAD, {I_OPQ, 4'h0}, 8'h56, {4'h5, {4{RNONE}}}), 0);
    send_beat(directed_beat(OP_LOAD, {I_OPQ, 4'h0}, 8'h56, {5{RNONE}}), 0);
    n_directed = sent;

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      calm = (i >= RANDOM_BEATS - CALM_TAIL);
      case ($urandom_range(0, 99)) inside
        [0:79]:  b.op = OP_LOAD;
        [80:87]: b.op = OP_STALL;
        [88:95]: b.op = OP_BUBBLE;
        default: b.op = OP_RESERVED;
      endcase
      if ($urandom_range(0, 99) < 85) begin
        ic = 4'($urandom_range(I_NOP, I_POPQ));
      end else begin
        ic = 4'($urandom_range(0, 4));
        if (ic != 0) ic = ic + 4'd11;
      end
      ra = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
      rb = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
      b.stat = 3'($urandom_range(0, 7));
      b.code = {ic, 4'($urandom_range(0, 15))};
      b.regs = {ra, rb};
      b.valc = wide_rand();
      b.valp = wide_rand();
      for (int k = 0; k < 5; k++) begin
        b.fwd[k] = wide_rand();
        case ($urandom_range(0, 5))
          3:       b.dsts[4*k +: 4] = ra;
          4:       b.dsts[4*k +: 4] = rb;
          5:       b.dsts[4*k +: 4] = $urandom_range(0, 1) ? RSP : 4'($urandom_range(0, 15));
          default: b.dsts[4*k +: 4] = RNONE;
        endcase
      end
      // some beats leave every operand to the register file
      if ($urandom_range(0, 7) == 0) b.dsts = {5{RNONE}};
      gap = 0;
      if (!calm && (sent / 64) % 3 != 2 && $urandom_range(0, 5) == 0)
        gap = $urandom_range(1, 14);
      send_beat(b, gap);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(negedge clk);

    $display("Drove %0d beats (%0d directed, rest random over all ops and icodes),",
             sent, n_directed);
    $display("checked %0d decoded results, with idle bursts and one long output hold-off.",
             checked);
    if (errors == 0 && pending == 0)
      $display("pipelined_decode_stage_forwarding: match");
    else
      $display("pipelined_decode_stage_forwarding: mismatch");
    $finish;
  end

endmodule

// File: pipelined_decode_stage_forwarding.f
sv/pdsf_pkg.sv
sv/pdsf_regfile.sv
sv/pdsf_fwd.sv
sv/pipelined_decode_stage_forwarding.sv
tb/sv/decode_stage_checker.sv
tb/sv/pipelined_decode_stage_forwarding_tb.sv
